// ----- hdl/mmio_bus_decoder_with_crt_dma_setup_assert.svh -----
// Assertion macros for the bus decoder checker
`ifndef MMIO_BUS_DECODER_WITH_CRT_DMA_SETUP_ASSERT_SVH
`define MMIO_BUS_DECODER_WITH_CRT_DMA_SETUP_ASSERT_SVH

// Same-cycle implication, checked once reset is released
`define MBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked once reset is released
`define MBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mbd_pkg.sv -----
// Shared constants, codes and interface types of the bus decoder
package mbd_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int DIV_STEPS = 14;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // operations
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;

    // event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_DRAW   = 3'd1;
    localparam logic [2:0] EV_CURSOR = 3'd2;
    localparam logic [2:0] EV_RECONF = 3'd3;
    localparam logic [2:0] EV_AREA   = 3'd4;

    // bus addresses
    localparam logic [15:0] ADDR_KBD_SEL  = 16'h8000;
    localparam logic [15:0] ADDR_KBD_ROWS = 16'h8001;
    localparam logic [15:0] ADDR_KBD_MODS = 16'h8002;
    localparam logic [15:0] ADDR_STATUS   = 16'hC001;
    localparam logic [15:0] ADDR_IGNORE   = 16'hF800;
    localparam logic [15:0] PERIPH_MASK   = 16'hEFFF;
    localparam logic [15:0] REG_CRT_DATA  = 16'hC000;
    localparam logic [15:0] REG_CRT_CMD   = 16'hC001;
    localparam logic [15:0] REG_DMA_ADDR  = 16'hE004;
    localparam logic [15:0] REG_DMA_LEN   = 16'hE005;
    localparam logic [15:0] REG_DMA_MODE  = 16'hE008;

    // command bytes and field masks
    localparam logic [7:0] CMD_SEQ_START = 8'h80;
    localparam logic [7:0] CMD_FORMAT    = 8'h00;
    localparam logic [7:0] CMD_CH_START  = 8'hA4;
    localparam logic [7:0] WIDTH_MASK    = 8'h7F;
    localparam logic [7:0] HEIGHT_MASK   = 8'h3F;
    localparam logic [15:0] SIZE_MASK    = 16'h3FFF;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic exec;
        logic div_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_div;
        logic div_last;
    } t_dp_stat;

endpackage

// ----- hdl/mmio_bus_decoder_with_crt_dma_setup.sv -----
// Top level of the bus decoder with CRT and DMA setup tracking
//
// Usage
//   Input channel: a transaction (op, address, write data, keyboard rows and
//   modifiers) is taken at a rising edge with start high and busy low.
//   Output channel: every transaction gives exactly one result, shown for a
//   single cycle with o_done high. The receiver cannot hold it off.
// Flow
//   Reads, preloads, register writes and plain stores: latched at the
//   accepting edge, then run in the execute state, which registers the
//   strobe; a new transaction is taken only once the last one is through.
//   A store into the active video area also runs the offset divider, one
//   quotient bit a cycle, before its strobe. The byte store, read at the
//   accepting edge, feeds the execute state; the restoring divider follows.
// Reset
//   Synchronous, active low. All CRT/DMA state clears at once; then a
//   clearing pass writes zero to all 65536 store bytes, one per cycle, with
//   busy held high throughout the pass.
// Stall
//   None: results are never back-pressured, so busy depends on internal work
//   only. A new transaction may be taken in the cycle its predecessor's
//   result is on the ports.
module mmio_bus_decoder_with_crt_dma_setup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [63:0] i_key_rows,
    input  logic [7:0]  i_key_modifiers,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_col_value,
    output logic [13:0] o_row_value,
    output logic [7:0]  o_char_code,
    output logic [15:0] o_area_base,
    output logic [14:0] o_area_size
);

    mbd_pkg::t_dp_cmd  dp_cmd;
    mbd_pkg::t_dp_stat dp_stat;

    // controller: clearing pass, accept, execute, divide
    mbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // datapath: store, decode, sequence tracking, divider, result registers
    mbd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_write_data    (i_write_data),
        .i_key_rows      (i_key_rows),
        .i_key_modifiers (i_key_modifiers),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_event_kind    (o_event_kind),
        .o_col_value     (o_col_value),
        .o_row_value     (o_row_value),
        .o_char_code     (o_char_code),
        .o_area_base     (o_area_base),
        .o_area_size     (o_area_size)
    );

endmodule

// ----- hdl/mbd_ctrl.sv -----
// Sequencing state machine of the bus decoder
module mbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mbd_pkg::t_dp_stat i_stat,
    output mbd_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_DIV} t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_stat.clear_last) r_state <= S_IDLE;
                S_IDLE:  if (start) r_state <= S_EXEC;
                S_EXEC:  r_state <= i_stat.need_div ? S_DIV : S_IDLE;
                S_DIV:   if (i_stat.div_last) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cmd.clear    = (r_state == S_CLEAR);
    assign o_cmd.load     = (r_state == S_IDLE) && start;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.div_step = (r_state == S_DIV);

endmodule

// ----- hdl/mbd_datapath.sv -----
// Byte store, peripheral decode, CRT/DMA tracking and offset divider
module mbd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbd_pkg::t_dp_cmd  i_cmd,
    output mbd_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_op,
    input  logic [15:0]       i_address,
    input  logic [7:0]        i_write_data,
    input  logic [63:0]       i_key_rows,
    input  logic [7:0]        i_key_modifiers,
    output logic              o_done,
    output logic [7:0]        o_read_data,
    output logic [2:0]        o_event_kind,
    output logic [7:0]        o_col_value,
    output logic [13:0]       o_row_value,
    output logic [7:0]        o_char_code,
    output logic [15:0]       o_area_base,
    output logic [14:0]       o_area_size
);

    logic [7:0] r_mem [0:mbd_pkg::MEM_BYTES-1];
    logic [7:0] r_mem_rd;
    logic [mbd_pkg::MEM_AW-1:0] r_clr_cnt;
    logic [7:0] r_kbd_sel;

    // latched transaction
    logic [1:0]  r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [63:0] r_rows;
    logic [7:0]  r_mods;

    // CRT / DMA state
    logic [1:0]  r_cursor_seq, n_cursor_seq;
    logic [1:0]  r_format_seq, n_format_seq;
    logic [2:0]  r_dma_seq, n_dma_seq;
    logic [7:0]  r_p_col, n_p_col;
    logic [7:0]  r_p_width, n_p_width;
    logic [6:0]  r_p_height, n_p_height;
    logic [15:0] r_p_base, n_p_base;
    logic [14:0] r_p_size, n_p_size;
    logic [7:0]  r_a_width, n_a_width;
    logic [6:0]  r_a_height, n_a_height;
    logic [15:0] r_a_base, n_a_base;
    logic [14:0] r_a_size, n_a_size;

    // divider
    logic [8:0]  r_div_rem;
    logic [13:0] r_div_quo;
    logic [7:0]  r_div_w;
    logic [7:0]  r_div_char;
    logic [mbd_pkg::DIV_CW-1:0] r_div_cnt;
    logic [8:0]  div_trial;
    logic        div_ge;

    // decode results
    logic        mem_we;
    logic [mbd_pkg::MEM_AW-1:0] mem_wa;
    logic [7:0]  mem_wd;
    logic        store_wr;
    logic        draw_hit;
    logic [16:0] area_end;
    logic [15:0] draw_off;
    logic [15:0] reg_addr;
    logic [7:0]  kbd_val;
    logic [7:0]  n_rd;
    logic [2:0]  n_ev;
    logic [7:0]  n_col;
    logic [13:0] n_row;
    logic [15:0] n_base;
    logic [14:0] n_size;

    always_comb begin
        kbd_val = 8'hFF;
        for (int i = 0; i < 8; i++) begin
            if (!r_kbd_sel[i]) kbd_val = kbd_val & r_rows[8*i +: 8];
        end
    end

    assign store_wr = (r_op == mbd_pkg::OP_WRITE) && (r_addr <= mbd_pkg::ADDR_KBD_SEL);
    assign area_end = {1'b0, r_a_base} + {2'b00, r_a_size};
    assign draw_hit = store_wr && (r_a_width != 8'd0) && (r_a_size != 15'd0)
                      && (r_addr >= r_a_base) && ({1'b0, r_addr} < area_end);
    assign draw_off = r_addr - r_a_base;
    assign reg_addr = r_addr & mbd_pkg::PERIPH_MASK;

    always_comb begin
        n_cursor_seq = r_cursor_seq;
        n_format_seq = r_format_seq;
        n_dma_seq    = r_dma_seq;
        n_p_col      = r_p_col;
        n_p_width    = r_p_width;
        n_p_height   = r_p_height;
        n_p_base     = r_p_base;
        n_p_size     = r_p_size;
        n_a_width    = r_a_width;
        n_a_height   = r_a_height;
        n_a_base     = r_a_base;
        n_a_size     = r_a_size;
        n_rd         = 8'd0;
        n_ev         = mbd_pkg::EV_NONE;
        n_col        = 8'd0;
        n_row        = 14'd0;
        n_base       = 16'd0;
        n_size       = 15'd0;
        if (r_op == mbd_pkg::OP_READ) begin
            if (r_addr == mbd_pkg::ADDR_KBD_MODS)      n_rd = r_mods;
            else if (r_addr == mbd_pkg::ADDR_KBD_ROWS) n_rd = kbd_val;
            else if (r_addr == mbd_pkg::ADDR_STATUS)   n_rd = 8'hFF;
            else                                       n_rd = r_mem_rd;
        end else if (r_op == mbd_pkg::OP_WRITE && r_addr > mbd_pkg::ADDR_KBD_SEL
                     && r_addr < mbd_pkg::ADDR_IGNORE) begin
            if (reg_addr == mbd_pkg::REG_CRT_CMD && r_wdata == mbd_pkg::CMD_SEQ_START) begin
                n_cursor_seq = 2'd1;
            end else if (reg_addr == mbd_pkg::REG_CRT_DATA && r_cursor_seq == 2'd1) begin
                n_p_col = r_wdata;
                n_cursor_seq = 2'd2;
            end else if (reg_addr == mbd_pkg::REG_CRT_DATA && r_cursor_seq == 2'd2) begin
                n_ev = mbd_pkg::EV_CURSOR;
                n_col = r_p_col;
                n_row = {6'd0, r_wdata};
                n_cursor_seq = 2'd0;
            end else if (reg_addr == mbd_pkg::REG_CRT_CMD && r_wdata == mbd_pkg::CMD_FORMAT) begin
                n_format_seq = 2'd1;
            end else if (reg_addr == mbd_pkg::REG_CRT_DATA && r_format_seq == 2'd1) begin
                n_p_width = (r_wdata & mbd_pkg::WIDTH_MASK) + 8'd1;
                n_format_seq = 2'd2;
            end else if (reg_addr == mbd_pkg::REG_CRT_DATA && r_format_seq == 2'd2) begin
                n_p_height = r_wdata[6:0] & mbd_pkg::HEIGHT_MASK[6:0];
                n_p_height = n_p_height + 7'd1;
                n_format_seq = 2'd0;
            end else if (reg_addr == mbd_pkg::REG_DMA_MODE && r_wdata == mbd_pkg::CMD_SEQ_START) begin
                n_dma_seq = 3'd1;
            end else if (reg_addr == mbd_pkg::REG_DMA_ADDR && r_dma_seq == 3'd1) begin
                n_p_base = {8'd0, r_wdata};
                n_dma_seq = 3'd2;
            end else if (reg_addr == mbd_pkg::REG_DMA_ADDR && r_dma_seq == 3'd2) begin
                n_p_base = {r_wdata, r_p_base[7:0]};
                n_dma_seq = 3'd3;
            end else if (reg_addr == mbd_pkg::REG_DMA_LEN && r_dma_seq == 3'd3) begin
                n_p_size = {7'd0, r_wdata};
                n_dma_seq = 3'd4;
            end else if (reg_addr == mbd_pkg::REG_DMA_LEN && r_dma_seq == 3'd4) begin
                n_p_size = {1'b0, r_wdata[5:0], r_p_size[7:0]} + 15'd1;
                n_dma_seq = 3'd0;
            end else if (reg_addr == mbd_pkg::REG_DMA_MODE && r_wdata == mbd_pkg::CMD_CH_START
                         && r_p_width != 8'd0 && r_p_height != 7'd0) begin
                if (r_a_width != r_p_width || r_a_height != r_p_height) begin
                    n_a_width = r_p_width;
                    n_a_height = r_p_height;
                    n_a_base = r_p_base;
                    n_a_size = r_p_size;
                    n_ev = mbd_pkg::EV_RECONF;
                    n_col = r_p_width;
                    n_row = {7'd0, r_p_height};
                    n_base = r_p_base;
                    n_size = r_p_size;
                end else if (r_a_base != r_p_base || r_a_size != r_p_size) begin
                    n_a_base = r_p_base;
                    n_a_size = r_p_size;
                    n_ev = mbd_pkg::EV_AREA;
                    n_base = r_p_base;
                    n_size = r_p_size;
                end
            end
        end
    end

    // store write port: clearing sweep, or the executing transaction
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr[mbd_pkg::MEM_AW-1:0];
        mem_wd = r_wdata;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
            mem_wa = r_clr_cnt;
            mem_wd = 8'd0;
        end else if (i_cmd.exec && (store_wr || r_op == mbd_pkg::OP_PRELOAD)) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_mem_rd <= r_mem[i_address[mbd_pkg::MEM_AW-1:0]];
    end

    assign div_trial = {r_div_rem[7:0], r_div_quo[13]};
    assign div_ge    = (div_trial >= {1'b0, r_div_w});

    // payload, divider and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
            r_rows  <= i_key_rows;
            r_mods  <= i_key_modifiers;
        end
        if (i_cmd.exec) begin
            r_div_rem  <= 9'd0;
            r_div_quo  <= draw_off[13:0];
            r_div_w    <= r_a_width;
            r_div_char <= r_wdata;
            o_read_data  <= n_rd;
            o_event_kind <= n_ev;
            o_col_value  <= n_col;
            o_row_value  <= n_row;
            o_char_code  <= 8'd0;
            o_area_base  <= n_base;
            o_area_size  <= n_size;
        end else if (i_cmd.div_step) begin
            r_div_rem <= div_ge ? (div_trial - {1'b0, r_div_w}) : div_trial;
            r_div_quo <= {r_div_quo[12:0], div_ge};
            if (o_stat.div_last) begin
                o_read_data  <= 8'd0;
                o_event_kind <= mbd_pkg::EV_DRAW;
                o_col_value  <= div_ge ? (div_trial[7:0] - r_div_w) : div_trial[7:0];
                o_row_value  <= {r_div_quo[12:0], div_ge};
                o_char_code  <= r_div_char;
                o_area_base  <= 16'd0;
                o_area_size  <= 15'd0;
            end
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_kbd_sel    <= 8'd0;
            r_cursor_seq <= 2'd0;
            r_format_seq <= 2'd0;
            r_dma_seq    <= 3'd0;
            r_p_col      <= 8'd0;
            r_p_width    <= 8'd0;
            r_p_height   <= 7'd0;
            r_p_base     <= 16'd0;
            r_p_size     <= 15'd0;
            r_a_width    <= 8'd0;
            r_a_height   <= 7'd0;
            r_a_base     <= 16'd0;
            r_a_size     <= 15'd0;
            r_div_cnt    <= '0;
            o_done       <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cmd.clear) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.exec) begin
                if ((store_wr || r_op == mbd_pkg::OP_PRELOAD)
                    && r_addr == mbd_pkg::ADDR_KBD_SEL) begin
                    r_kbd_sel <= r_wdata;
                end
                r_cursor_seq <= n_cursor_seq;
                r_format_seq <= n_format_seq;
                r_dma_seq    <= n_dma_seq;
                r_p_col      <= n_p_col;
                r_p_width    <= n_p_width;
                r_p_height   <= n_p_height;
                r_p_base     <= n_p_base;
                r_p_size     <= n_p_size;
                r_a_width    <= n_a_width;
                r_a_height   <= n_a_height;
                r_a_base     <= n_a_base;
                r_a_size     <= n_a_size;
                r_div_cnt    <= '0;
                o_done       <= !draw_hit;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
                o_done    <= o_stat.div_last;
            end
        end
    end

    assign o_stat.clear_last = (r_clr_cnt == {mbd_pkg::MEM_AW{1'b1}});
    assign o_stat.need_div   = draw_hit;
    assign o_stat.div_last   = (r_div_cnt == mbd_pkg::DIV_CW'(mbd_pkg::DIV_STEPS - 1));

endmodule

// ----- hdl/mbd_checker.sv -----
// Port-level checks of the bus decoder and their binding
`include "mmio_bus_decoder_with_crt_dma_setup_assert.svh"

module mbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_event_kind,
    input logic [7:0]  o_col_value,
    input logic [13:0] o_row_value,
    input logic [7:0]  o_char_code,
    input logic [15:0] o_area_base,
    input logic [14:0] o_area_size
);

    `MBD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `MBD_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe repeated")
    `MBD_ASSERT_NOW(a_draw_no_area, o_done && o_event_kind == mbd_pkg::EV_DRAW, o_area_base == 16'd0 && o_area_size == 15'd0, "draw carries area fields")
    `MBD_ASSERT_NOW(a_cursor_fields, o_done && o_event_kind == mbd_pkg::EV_CURSOR, o_char_code == 8'd0 && o_area_size == 15'd0, "cursor move carries draw or area fields")
    `MBD_ASSERT_NOW(a_reconf_dims, o_done && o_event_kind == mbd_pkg::EV_RECONF, o_col_value != 8'd0 && o_col_value <= 8'd128 && o_row_value != 14'd0 && o_row_value <= 14'd64, "screen format out of range")

endmodule

bind mmio_bus_decoder_with_crt_dma_setup mbd_checker u_mbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_event_kind (o_event_kind),
    .o_col_value  (o_col_value),
    .o_row_value  (o_row_value),
    .o_char_code  (o_char_code),
    .o_area_base  (o_area_base),
    .o_area_size  (o_area_size)
);

// ----- tb/sv/mmio_bus_decoder_with_crt_dma_setup_tb.sv -----
// Self-checking testbench for the bus decoder with CRT and DMA setup tracking
`timescale 1ns / 1ps

module mmio_bus_decoder_with_crt_dma_setup_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_ITEMS     = 1400;
    localparam int QUIET_TAIL  = 200;      // last transactions sent with no gaps
    localparam int STALL_LIMIT = 200000;   // covers the clearing pass over all 65536 store bytes

    typedef struct packed {
        logic [7:0]  rd;
        logic [2:0]  kind;
        logic [7:0]  col;
        logic [13:0] row;
        logic [7:0]  chr;
        logic [15:0] base;
        logic [14:0] size;
    } t_bus_result;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [63:0] rows;
        logic [7:0]  mods;
        bit          typed;   // expected result written out by hand
        t_bus_result res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_op = '0;
    logic [15:0] i_address = '0;
    logic [7:0]  i_write_data = '0;
    logic [63:0] i_key_rows = '0;
    logic [7:0]  i_key_modifiers = '0;
    logic        o_done;
    logic [7:0]  o_read_data;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_col_value;
    logic [13:0] o_row_value;
    logic [7:0]  o_char_code;
    logic [15:0] o_area_base;
    logic [14:0] o_area_size;

    mmio_bus_decoder_with_crt_dma_setup dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Shadow of the decoder state
    // ---------------------------------------------------------------
    logic [7:0]  mem_shadow [mbd_pkg::MEM_BYTES];
    logic [1:0]  cur_phase, fmt_phase;
    logic [2:0]  dma_phase;
    logic [7:0]  pend_col, pend_w, act_w;
    logic [6:0]  pend_h, act_h;
    logic [15:0] pend_base, act_base;
    logic [14:0] pend_size, act_size;

    t_bus_result results_due[$];
    int          n_fail = 0;
    int          n_seen[5] = '{default: 0};
    bit          send_typed;
    t_bus_result send_res;

    // Bus read as the CPU sees it
    function automatic logic [7:0] bus_read_byte(logic [15:0] a, logic [63:0] rows,
                                                 logic [7:0] mods);
        logic [7:0] acc;
        acc = 8'hFF;
        if (a == mbd_pkg::ADDR_KBD_MODS) return mods;
        if (a == mbd_pkg::ADDR_KBD_ROWS) begin
            // rows selected by zero bits of the scan byte are ANDed together
            for (int i = 0; i < 8; i++)
                if (!mem_shadow[mbd_pkg::ADDR_KBD_SEL][i]) acc &= rows[8*i +: 8];
            return acc;
        end
        if (a == mbd_pkg::ADDR_STATUS) return 8'hFF;
        return mem_shadow[a];
    endfunction

    // Work out the result of one transaction and advance the shadow state
    function automatic t_bus_result decode_access(logic [1:0] op, logic [15:0] a,
                                                  logic [7:0] b, logic [63:0] rows,
                                                  logic [7:0] mods);
        t_bus_result r;
        logic [15:0] reg_a;
        int          off;
        r = '0;
        case (op)
            mbd_pkg::OP_READ: r.rd = bus_read_byte(a, rows, mods);
            mbd_pkg::OP_PRELOAD: mem_shadow[a] = b;
            mbd_pkg::OP_WRITE: begin
                reg_a = a & mbd_pkg::PERIPH_MASK;
                if (a >= mbd_pkg::ADDR_IGNORE) begin
                    // top of the map swallows writes
                end else if (a <= mbd_pkg::ADDR_KBD_SEL) begin
                    if (act_w != 0 && act_size != 0 && int'(a) >= int'(act_base)
                        && int'(a) < int'(act_base) + int'(act_size)) begin
                        off    = int'(a) - int'(act_base);
                        r.kind = mbd_pkg::EV_DRAW;
                        r.col  = 8'(off % int'(act_w));
                        r.row  = 14'(off / int'(act_w));
                        r.chr  = b;
                    end
                    mem_shadow[a] = b;
                end else if (reg_a == mbd_pkg::REG_CRT_CMD && b == mbd_pkg::CMD_SEQ_START) begin
                    cur_phase = 2'd1;
                end else if (reg_a == mbd_pkg::REG_CRT_DATA && cur_phase == 2'd1) begin
                    pend_col = b; cur_phase = 2'd2;
                end else if (reg_a == mbd_pkg::REG_CRT_DATA && cur_phase == 2'd2) begin
                    r.kind = mbd_pkg::EV_CURSOR; r.col = pend_col; r.row = 14'(b);
                    cur_phase = 2'd0;
                end else if (reg_a == mbd_pkg::REG_CRT_CMD && b == mbd_pkg::CMD_FORMAT) begin
                    fmt_phase = 2'd1;
                end else if (reg_a == mbd_pkg::REG_CRT_DATA && fmt_phase == 2'd1) begin
                    pend_w = (b & mbd_pkg::WIDTH_MASK) + 8'd1; fmt_phase = 2'd2;
                end else if (reg_a == mbd_pkg::REG_CRT_DATA && fmt_phase == 2'd2) begin
                    pend_h = 7'(b & mbd_pkg::HEIGHT_MASK) + 7'd1; fmt_phase = 2'd0;
                end else if (reg_a == mbd_pkg::REG_DMA_MODE
                             && b == mbd_pkg::CMD_SEQ_START) begin
                    dma_phase = 3'd1;
                end else if (reg_a == mbd_pkg::REG_DMA_ADDR && dma_phase == 3'd1) begin
                    pend_base = {8'h00, b}; dma_phase = 3'd2;
                end else if (reg_a == mbd_pkg::REG_DMA_ADDR && dma_phase == 3'd2) begin
                    pend_base[15:8] = b; dma_phase = 3'd3;
                end else if (reg_a == mbd_pkg::REG_DMA_LEN && dma_phase == 3'd3) begin
                    pend_size = 15'(b); dma_phase = 3'd4;
                end else if (reg_a == mbd_pkg::REG_DMA_LEN && dma_phase == 3'd4) begin
                    pend_size = 15'(({b, pend_size[7:0]} & mbd_pkg::SIZE_MASK)) + 15'd1;
                    dma_phase = 3'd0;
                end else if (reg_a == mbd_pkg::REG_DMA_MODE && b == mbd_pkg::CMD_CH_START
                             && pend_w != 0 && pend_h != 0) begin
                    if (act_w != pend_w || act_h != pend_h) begin
                        act_w = pend_w; act_h = pend_h;
                        act_base = pend_base; act_size = pend_size;
                        r.kind = mbd_pkg::EV_RECONF; r.col = act_w; r.row = 14'(act_h);
                        r.base = act_base; r.size = act_size;
                    end else if (act_base != pend_base || act_size != pend_size) begin
                        act_base = pend_base; act_size = pend_size;
                        r.kind = mbd_pkg::EV_AREA; r.base = act_base; r.size = act_size;
                    end
                end
            end
            default: ;   // unused op: all-zero result
        endcase
        return r;
    endfunction

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            n_fail++;
        end
    endtask

    // ---------------------------------------------------------------
    // Acceptance, result checking and watchdog, all on the rising edge
    // ---------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        t_bus_result exp_r, pred;
        if (i_rst_n) begin
            if (o_done || (start && !busy)) idle_cycles <= 0;
            else                            idle_cycles <= idle_cycles + 1;
            if (o_done) begin
                if (results_due.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    n_fail++;
                end else begin
                    exp_r = results_due.pop_front();
                    check_field("read_data",  exp_r.rd,   o_read_data);
                    check_field("event_kind", exp_r.kind, o_event_kind);
                    check_field("col_value",  exp_r.col,  o_col_value);
                    check_field("row_value",  exp_r.row,  o_row_value);
                    check_field("char_code",  exp_r.chr,  o_char_code);
                    check_field("area_base",  exp_r.base, o_area_base);
                    check_field("area_size",  exp_r.size, o_area_size);
                    if (o_event_kind <= mbd_pkg::EV_AREA) n_seen[o_event_kind]++;
                end
            end
            if (start && !busy) begin
                pred = decode_access(i_op, i_address, i_write_data, i_key_rows,
                                     i_key_modifiers);
                results_due.push_back(send_typed ? send_res : pred);
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int n_sent = 0;
    bit gaps_on = 1'b1;

    // One transaction: optional idle burst, then hold start until taken
    task automatic send_access(logic [1:0] op, logic [15:0] a, logic [7:0] b,
                               logic [63:0] rows, logic [7:0] mods,
                               bit typed = 1'b0, t_bus_result res = '0);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_op <= op; i_address <= a; i_write_data <= b;
        i_key_rows <= rows; i_key_modifiers <= mods;
        send_typed <= typed; send_res <= res;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic logic [63:0] rand_rows();
        return {$urandom, $urandom};
    endfunction

    task automatic send_write(logic [15:0] a, logic [7:0] b);
        send_access(mbd_pkg::OP_WRITE, a, b, rand_rows(), 8'($urandom));
    endtask

    // Mirror copy of a peripheral register through address bit 12, where the
    // mirror still lies below the ignored top of the map
    function automatic logic [15:0] alias_of(logic [15:0] reg_a);
        logic [15:0] mirror;
        mirror = reg_a | 16'h1000;
        return ($urandom_range(0, 1) && mirror < mbd_pkg::ADDR_IGNORE) ? mirror : reg_a;
    endfunction

    task automatic rand_format();
        send_write(alias_of(mbd_pkg::REG_CRT_CMD), mbd_pkg::CMD_FORMAT);
        send_write(alias_of(mbd_pkg::REG_CRT_DATA), 8'($urandom));
        send_write(alias_of(mbd_pkg::REG_CRT_DATA), 8'($urandom));
    endtask

    task automatic rand_dma();
        logic [15:0] base;
        base = 16'($urandom_range(0, 16'h8000));
        send_write(alias_of(mbd_pkg::REG_DMA_MODE), mbd_pkg::CMD_SEQ_START);
        send_write(alias_of(mbd_pkg::REG_DMA_ADDR), base[7:0]);
        // occasionally poke the wrong register mid-sequence
        if ($urandom_range(0, 7) == 0)
            send_write(alias_of(mbd_pkg::REG_DMA_LEN), 8'($urandom));
        send_write(alias_of(mbd_pkg::REG_DMA_ADDR), base[15:8]);
        send_write(alias_of(mbd_pkg::REG_DMA_LEN), 8'($urandom));
        send_write(alias_of(mbd_pkg::REG_DMA_LEN),
                   $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
    endtask

    task automatic rand_cursor();
        send_write(alias_of(mbd_pkg::REG_CRT_CMD), mbd_pkg::CMD_SEQ_START);
        send_write(alias_of(mbd_pkg::REG_CRT_DATA), 8'($urandom));
        send_write(alias_of(mbd_pkg::REG_CRT_DATA), 8'($urandom));
    endtask

    task automatic rand_transaction();
        int          pick;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            // store into or around the active area
            a = act_base + 16'($urandom_range(0, int'(act_size) + 8));
            if (a > mbd_pkg::ADDR_KBD_SEL) a = 16'($urandom_range(0, 16'h8000));
            send_write(a, 8'($urandom));
        end else if (pick < 40) begin
            a = 16'($urandom_range(0, 4) == 0 ? mbd_pkg::ADDR_KBD_ROWS
                                              : $urandom_range(0, 16'h8000));
            send_access(mbd_pkg::OP_READ, a, 8'($urandom), rand_rows(), 8'($urandom));
        end else if (pick < 48) begin
            case ($urandom_range(0, 3))
                0: a = mbd_pkg::ADDR_KBD_ROWS;
                1: a = mbd_pkg::ADDR_KBD_MODS;
                2: a = mbd_pkg::ADDR_STATUS;
                default: a = mbd_pkg::ADDR_KBD_SEL;
            endcase
            send_access(mbd_pkg::OP_READ, a, 8'($urandom), rand_rows(), 8'($urandom));
        end else if (pick < 54) begin
            send_access($urandom_range(0, 5) == 0 ? OP_UNUSED : mbd_pkg::OP_PRELOAD,
                        $urandom_range(0, 1) ? mbd_pkg::ADDR_KBD_SEL : 16'($urandom),
                        8'($urandom), rand_rows(), 8'($urandom));
        end else if (pick < 62) begin
            rand_format();
        end else if (pick < 70) begin
            rand_dma();
        end else if (pick < 80) begin
            send_write(alias_of(mbd_pkg::REG_DMA_MODE), mbd_pkg::CMD_CH_START);
        end else if (pick < 88) begin
            rand_cursor();
        end else begin
            // raw noise over the whole map, any op
            send_access(2'($urandom), 16'($urandom), 8'($urandom), rand_rows(), 8'($urandom));
        end
    endtask

    // Directed transactions; typed results only where obvious
    t_stim_row directed[] = '{
        // fresh store reads back zero at both ends of the map
        '{mbd_pkg::OP_READ,  16'h0000, 8'h5A, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_READ,  16'hFFFF, 8'h00, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_READ,  mbd_pkg::ADDR_STATUS, 8'h00, 64'h0, 8'h00, 1'b1,
          '{8'hFF, mbd_pkg::EV_NONE, 8'h0, 14'h0, 8'h0, 16'h0, 15'h0}},
        '{mbd_pkg::OP_READ,  mbd_pkg::ADDR_KBD_MODS, 8'h00, 64'h0, 8'hA5, 1'b1,
          '{8'hA5, mbd_pkg::EV_NONE, 8'h0, 14'h0, 8'h0, 16'h0, 15'h0}},
        // scan byte zero selects all rows
        '{mbd_pkg::OP_READ,  mbd_pkg::ADDR_KBD_ROWS, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF,
          8'h00, 1'b1, '{8'hFF, mbd_pkg::EV_NONE, 8'h0, 14'h0, 8'h0, 16'h0, 15'h0}},
        '{mbd_pkg::OP_PRELOAD, mbd_pkg::ADDR_KBD_SEL, 8'hFE, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_READ,  mbd_pkg::ADDR_KBD_ROWS, 8'h00, 64'hFFFF_FFFF_FFFF_FF3C,
          8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::ADDR_IGNORE, 8'hFF, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_READ,  16'hFFFF, 8'h00, 64'h0, 8'h00, 1'b1, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::ADDR_KBD_SEL, 8'h00, 64'h0, 8'h00, 1'b0, '0},
        // channel start with no format yet does nothing
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_MODE, mbd_pkg::CMD_CH_START, 64'h0, 8'h00,
          1'b1, '0},
        // format 16 x 4 via the mirror alias
        '{mbd_pkg::OP_WRITE, 16'hD001, mbd_pkg::CMD_FORMAT, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_CRT_DATA, 8'h8F, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, 16'hD000, 8'hC3, 64'h0, 8'h00, 1'b0, '0},
        // DMA area 0x1000, length 64, wrong-register write in the middle
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_MODE, mbd_pkg::CMD_SEQ_START, 64'h0, 8'h00,
          1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_ADDR, 8'h00, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_LEN, 8'h77, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_ADDR, 8'h10, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_LEN, 8'h3F, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_LEN, 8'hC0, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_DMA_MODE, mbd_pkg::CMD_CH_START, 64'h0, 8'h00,
          1'b1, '{8'h00, mbd_pkg::EV_RECONF, 8'd16, 14'd4, 8'h0, 16'h1000, 15'd64}},
        // draws at both ends of the area and one just past it
        '{mbd_pkg::OP_WRITE, 16'h1000, 8'h41, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, 16'h103F, 8'h42, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, 16'h1040, 8'h43, 64'h0, 8'h00, 1'b0, '0},
        // cursor sequence, row written through the mirror alias
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_CRT_CMD, mbd_pkg::CMD_SEQ_START, 64'h0, 8'h00,
          1'b0, '0},
        '{mbd_pkg::OP_WRITE, mbd_pkg::REG_CRT_DATA, 8'hFF, 64'h0, 8'h00, 1'b0, '0},
        '{mbd_pkg::OP_WRITE, 16'hD000, 8'hFF, 64'h0, 8'h00, 1'b1,
          '{8'h00, mbd_pkg::EV_CURSOR, 8'hFF, 14'h0FF, 8'h0, 16'h0, 15'h0}},
        '{OP_UNUSED, 16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, '0}
    };

    initial begin
        mem_shadow = '{default: 8'h00};
        cur_phase = '0; fmt_phase = '0; dma_phase = '0;
        pend_col = '0; pend_w = '0; pend_h = '0; pend_base = '0; pend_size = '0;
        act_w = '0; act_h = '0; act_base = '0; act_size = '0;
        send_typed = 1'b0; send_res = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_access(directed[k].op, directed[k].addr, directed[k].data,
                        directed[k].rows, directed[k].mods, directed[k].typed,
                        directed[k].res);

        // full-range format and largest area before the random mix
        send_write(mbd_pkg::REG_CRT_CMD, mbd_pkg::CMD_FORMAT);
        send_write(mbd_pkg::REG_CRT_DATA, 8'hFF);
        send_write(mbd_pkg::REG_CRT_DATA, 8'hFF);
        send_write(mbd_pkg::REG_DMA_MODE, mbd_pkg::CMD_SEQ_START);
        send_write(mbd_pkg::REG_DMA_ADDR, 8'h00);
        send_write(mbd_pkg::REG_DMA_ADDR, 8'h40);
        send_write(mbd_pkg::REG_DMA_LEN, 8'hFF);
        send_write(mbd_pkg::REG_DMA_LEN, 8'hFF);
        send_write(mbd_pkg::REG_DMA_MODE, mbd_pkg::CMD_CH_START);

        while (n_sent < N_ITEMS) begin
            gaps_on = (n_sent < N_ITEMS - QUIET_TAIL);
            rand_transaction();
        end
        start <= 1'b0;

        // drain: idle watchdog guards this wait too
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        $display("Ran %0d transactions: %0d plain, %0d draws, %0d cursor moves,",
                 n_sent, n_seen[mbd_pkg::EV_NONE], n_seen[mbd_pkg::EV_DRAW],
                 n_seen[mbd_pkg::EV_CURSOR]);
        $display("%0d screen reconfigures and %0d area refreshes.",
                 n_seen[mbd_pkg::EV_RECONF], n_seen[mbd_pkg::EV_AREA]);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
